@@ hw/rtl/aad_pkg.sv @@
// shared types and constants for the area average downscaler
// no dependencies
package aad_pkg;

    localparam int unsigned CFG_W   = 10;
    localparam int unsigned TGT_W   = 8;
    localparam int unsigned CFG_IDX = 2;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned NUM_CH  = 4;

    localparam logic [CFG_IDX-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX-1:0] REG_TARGET_SIZE   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_ADD,
        ST_DIVIDE,
        ST_OUT
    } aad_state_t;

endpackage

@@ hw/rtl/aad_stream_if.sv @@
// valid/ready channel carrying one request payload
// depends on nothing
interface aad_stream_if #(
    parameter int unsigned WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    logic             last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

@@ hw/rtl/aad_divider.sv @@
// restoring divider, one quotient bit per cycle, four channels in parallel
// depends on aad_pkg
module aad_divider #(
    parameter int unsigned WIDTH = 28
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [aad_pkg::NUM_CH*WIDTH-1:0]         dividend,
    input  logic [WIDTH-1:0]                         divisor,
    output logic                                     done,
    output logic [aad_pkg::NUM_CH*aad_pkg::CH_W-1:0] quotient
);
    import aad_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] num_reg [NUM_CH];
    logic [WIDTH-1:0] num_next [NUM_CH];
    logic [WIDTH:0]   rem_reg [NUM_CH];
    logic [WIDTH:0]   rem_next [NUM_CH];
    logic [WIDTH-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;

    always_comb
    begin
        logic [WIDTH:0] trial;
        trial     = '0;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            num_next[c] = num_reg[c];
            rem_next[c] = rem_reg[c];
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            for (int c = 0; c < NUM_CH; c++)
            begin
                num_next[c] = dividend[c*WIDTH +: WIDTH];
                rem_next[c] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                trial = {rem_reg[c][WIDTH-1:0], num_reg[c][WIDTH-1]};
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next[c] = trial - {1'b0, den_reg};
                    num_next[c] = {num_reg[c][WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = trial;
                    num_next[c] = {num_reg[c][WIDTH-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            num_reg[c] <= num_next[c];
            rem_reg[c] <= rem_next[c];
        end
    end

    assign done = busy_reg && cnt_reg == CNT_W'(1);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            quotient[c*CH_W +: CH_W] = num_next[c][CH_W-1:0];
        end
    end
endmodule

@@ hw/rtl/area_average_downscale.sv @@
// Area average downscaler for a square target. Source pixels enter in raster
// order, one request at a time; per-column channel sums live in one synchronous
// memory of MAX_TARGET words that is read, updated and written back per pixel,
// and the state machine takes no new pixel until the write back is done. A
// pixel that does not close a window is read, then added and written back. A
// pixel that closes a window also runs the shared divider, one cycle per sum
// bit (8 plus the bits of the largest width and height, 28 at the default
// sizes); its result is then loaded into the output register and the next
// pixel can be taken after that. The result waits in one output register
// while pixels keep coming; a later closing pixel waits until that register
// is free. After reset and after each write to a size register a clearing
// pass zeroes all MAX_TARGET sum words before pixels are taken. Sizes that
// would upscale or are out of range make the block take pixels and drop them.
// depends on aad_pkg, aad_stream_if, aad_divider
module area_average_downscale #(
    parameter int unsigned MAX_SOURCE_WIDTH  = 512,
    parameter int unsigned MAX_SOURCE_HEIGHT = 512,
    parameter int unsigned MAX_TARGET        = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [aad_pkg::CFG_IDX-1:0] cfg_index,
    input  logic [aad_pkg::CFG_W-1:0]   cfg_data,
    aad_stream_if.sink                  source,
    aad_stream_if.source                scaled
);
    import aad_pkg::*;

    localparam int unsigned AW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
    localparam int unsigned XW = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int unsigned YW = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int unsigned SW = CH_W + XW + YW;
    localparam int unsigned MW = CFG_W + TGT_W + 1;

    // configuration
    logic [CFG_W-1:0] w_reg, h_reg;
    logic [TGT_W-1:0] t_reg;
    logic             usable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= CFG_W'(512);
            h_reg <= CFG_W'(512);
            t_reg <= TGT_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  w_reg <= cfg_data;
                REG_SOURCE_HEIGHT: h_reg <= cfg_data;
                REG_TARGET_SIZE:   t_reg <= cfg_data[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    wire cfg_hit = cfg_we && (cfg_index == REG_SOURCE_WIDTH ||
        cfg_index == REG_SOURCE_HEIGHT || cfg_index == REG_TARGET_SIZE);

    assign usable = w_reg != '0 && h_reg != '0 && t_reg != '0 &&
        32'(w_reg) <= MAX_SOURCE_WIDTH && 32'(h_reg) <= MAX_SOURCE_HEIGHT &&
        32'(t_reg) <= MAX_TARGET && w_reg >= CFG_W'(t_reg) &&
        h_reg >= CFG_W'(t_reg);

    // sum memory
    logic [NUM_CH*SW-1:0] mem [MAX_TARGET];
    logic [NUM_CH*SW-1:0] rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [NUM_CH*SW-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[mem_raddr];
    end

    // state
    aad_state_t state_reg, state_next;
    logic [CFG_W-1:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [TGT_W-1:0] ocol_reg, ocol_next, orow_reg, orow_next;
    logic [CFG_W-1:0] cstart_reg, cstart_next, rstart_reg, rstart_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             ovalid_reg, ovalid_next;
    logic [PIX_W-1:0] px_reg;
    logic             close_reg, last_reg;
    logic [AW-1:0]    addr_reg;
    logic [CFG_W-1:0] cw_reg, rh_reg;
    logic [PIX_W-1:0] opix_reg;
    logic             olast_reg;

    logic                   load_out;
    logic [NUM_CH*SW-1:0]   sum_new;
    logic [2*CFG_W-1:0]     area;
    logic [SW-1:0]          div_den;
    logic                   div_start, div_done;
    logic [NUM_CH*CH_W-1:0] div_q;

    aad_divider #(.WIDTH(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_new),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    wire accept = source.valid && source.ready;
    wire take   = accept && usable;
    wire [CFG_W-1:0] scol_inc = scol_reg + CFG_W'(1);
    wire [CFG_W-1:0] srow_inc = srow_reg + CFG_W'(1);

    // window ends: pos+1 == floor((k+1)*len/t)
    logic [MW-1:0] col_lim, col_lo, col_hi, row_lim, row_lo, row_hi;
    assign col_lim = (MW'(ocol_reg) + MW'(1)) * MW'(w_reg);
    assign col_lo  = (MW'(scol_reg) + MW'(1)) * MW'(t_reg);
    assign col_hi  = col_lo + MW'(t_reg);
    assign row_lim = (MW'(orow_reg) + MW'(1)) * MW'(h_reg);
    assign row_lo  = (MW'(srow_reg) + MW'(1)) * MW'(t_reg);
    assign row_hi  = row_lo + MW'(t_reg);

    wire col_close = col_lo <= col_lim && col_lim < col_hi;
    wire row_close = row_lo <= row_lim && row_lim < row_hi;

    assign area    = (2*CFG_W)'(cw_reg) * (2*CFG_W)'(rh_reg);
    assign div_den = SW'(area);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_new[c*SW +: SW] = rd_data[c*SW +: SW] +
                SW'(px_reg[c*CH_W +: CH_W]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_TARGET - 1))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (take)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (close_reg)
                    state_next = ST_DIVIDE;
                else
                    state_next = ST_RUN;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || scaled.ready)
                    state_next = ST_RUN;
            end
            default: state_next = ST_CLEAR;
        endcase
        if (cfg_hit)
            state_next = ST_CLEAR;
    end

    // outputs
    always_comb
    begin
        mem_raddr = AW'(ocol_reg);
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_ADD:
            begin
                mem_we    = 1'b1;
                mem_wdata = close_reg ? '0 : sum_new;
                div_start = close_reg;
            end
            ST_OUT:
            begin
                load_out = !ovalid_reg || scaled.ready;
            end
            default: ;
        endcase
    end

    // position counters and output flag
    always_comb
    begin
        scol_next   = scol_reg;
        srow_next   = srow_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        cstart_next = cstart_reg;
        rstart_next = rstart_reg;
        clr_next    = (state_reg == ST_CLEAR) ? clr_reg + AW'(1) : '0;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && scaled.ready)
            ovalid_next = 1'b0;
        if (load_out)
            ovalid_next = 1'b1;
        if (cfg_hit)
        begin
            scol_next   = '0;
            srow_next   = '0;
            ocol_next   = '0;
            orow_next   = '0;
            cstart_next = '0;
            rstart_next = '0;
            clr_next    = '0;
        end
        else if (take)
        begin
            if (scol_inc < w_reg)
            begin
                scol_next = scol_inc;
                if (col_close)
                begin
                    ocol_next   = ocol_reg + TGT_W'(1);
                    cstart_next = scol_inc;
                end
            end
            else
            begin
                scol_next   = '0;
                ocol_next   = '0;
                cstart_next = '0;
                if (srow_inc < h_reg)
                begin
                    srow_next = srow_inc;
                    if (row_close)
                    begin
                        orow_next   = orow_reg + TGT_W'(1);
                        rstart_next = srow_inc;
                    end
                end
                else
                begin
                    srow_next   = '0;
                    orow_next   = '0;
                    rstart_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            scol_reg   <= '0;
            srow_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            cstart_reg <= '0;
            rstart_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            scol_reg   <= scol_next;
            srow_reg   <= srow_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            cstart_reg <= cstart_next;
            rstart_reg <= rstart_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= source.data;
            close_reg <= col_close && row_close;
            last_reg  <= ocol_reg + TGT_W'(1) == t_reg &&
                         orow_reg + TGT_W'(1) == t_reg;
            addr_reg  <= AW'(ocol_reg);
            cw_reg    <= scol_inc - cstart_reg;
            rh_reg    <= srow_inc - rstart_reg;
        end
        if (load_out)
        begin
            opix_reg  <= div_q;
            olast_reg <= last_reg;
        end
    end

    assign source.ready = state_reg == ST_RUN;

    assign scaled.valid = ovalid_reg;
    assign scaled.data  = opix_reg;
    assign scaled.last  = olast_reg;
endmodule

@@ hw/rtl/aad_checker.sv @@
// port-level checks for the area average downscaler
// depends on aad_pkg and the top level's ports
module aad_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [aad_pkg::PIX_W-1:0]     out_data,
    input logic                          cfg_we,
    input logic [aad_pkg::CFG_IDX-1:0]   cfg_index
);
    import aad_pkg::*;

    logic cfg_hit;
    assign cfg_hit = cfg_we && (cfg_index == REG_SOURCE_WIDTH ||
        cfg_index == REG_SOURCE_HEIGHT || cfg_index == REG_TARGET_SIZE);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request dropped while stalled");
    a_cfg_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !in_ready)
        else $error("input taken during clearing pass");
    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("handshake signal unknown");
    a_out_data_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("output request carries unknown data");
endmodule

bind area_average_downscale aad_checker u_aad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (source.ready),
    .out_valid (scaled.valid),
    .out_ready (scaled.ready),
    .out_data  (scaled.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);

@@ tb/sv/tb_area_average_downscale.sv @@
`timescale 1ns / 100ps
// self-checking testbench for area_average_downscale: random and directed frames
// predicted by a scoreboard class; depends on aad_pkg, aad_stream_if and the block
module tb_area_average_downscale;

    import aad_pkg::*;

    localparam int unsigned TARGET_ITEMS = 1650;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam logic [1:0]  REG_NONE     = 2'd3;

    class downscale_scoreboard;
        bit [9:0]  width_r;
        bit [9:0]  height_r;
        bit [7:0]  target_r;
        bit [25:0] acc_b [128];
        bit [25:0] acc_g [128];
        bit [25:0] acc_r [128];
        bit [25:0] acc_a [128];
        bit [9:0]  src_col;
        bit [9:0]  src_row;
        bit [6:0]  win_col;
        bit [6:0]  win_row;
        bit [32:0] expected [$];
        int        errors;

        function new();
            width_r  = 512;
            height_r = 512;
            target_r = 128;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 128; i++)
            begin
                acc_b[i] = 0;
                acc_g[i] = 0;
                acc_r[i] = 0;
                acc_a[i] = 0;
            end
            src_col = 0;
            src_row = 0;
            win_col = 0;
            win_row = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [9:0] value);
            if (idx == REG_SOURCE_WIDTH)
                width_r = value;
            else if (idx == REG_SOURCE_HEIGHT)
                height_r = value;
            else if (idx == REG_TARGET_SIZE)
                target_r = value[7:0];
            else
                return;
            restart();
        endfunction

        function bit usable();
            if (width_r == 0 || height_r == 0 || target_r == 0)
                return 0;
            if (width_r > 512 || height_r > 512 || target_r > 128)
                return 0;
            return width_r >= target_r && height_r >= target_r;
        endfunction

        // returns 1 when the pixel is taken into the frame
        function bit note_pixel(bit [31:0] px);
            int unsigned w, h, t, right, bottom, left, top, n;
            bit [7:0] b, g, r, a;
            bit       done_bit;
            w = width_r;
            h = height_r;
            t = target_r;
            if (!usable())
                return 0;
            if (win_col >= t || win_row >= t || src_col >= w || src_row >= h)
                restart();
            right  = (win_col + 1) * w / t;
            bottom = (win_row + 1) * h / t;
            left   = win_col * w / t;
            top    = win_row * h / t;
            acc_b[win_col] += px[7:0];
            acc_g[win_col] += px[15:8];
            acc_r[win_col] += px[23:16];
            acc_a[win_col] += px[31:24];
            if (src_col + 1 == right && src_row + 1 == bottom)
            begin
                n = (right - left) * (bottom - top);
                if (n == 0)
                    n = 1;
                b = acc_b[win_col] / n;
                g = acc_g[win_col] / n;
                r = acc_r[win_col] / n;
                a = acc_a[win_col] / n;
                done_bit = (win_col + 1 == t) && (win_row + 1 == t);
                expected.insert(expected.size(), {done_bit, a, r, g, b});
                acc_b[win_col] = 0;
                acc_g[win_col] = 0;
                acc_r[win_col] = 0;
                acc_a[win_col] = 0;
            end
            if (src_col + 1 < w)
            begin
                src_col++;
                if (src_col == right)
                    win_col++;
            end
            else
            begin
                src_col = 0;
                win_col = 0;
                src_row++;
                if (src_row >= h)
                begin
                    src_row = 0;
                    win_row = 0;
                end
                else if (src_row == bottom)
                    win_row++;
            end
            return 1;
        endfunction

        function void check_result(bit [31:0] pix, bit done);
            bit [32:0] want;
            if (expected.size() == 0)
            begin
                $error("unexpected output pixel %h", pix);
                errors++;
                return;
            end
            want = expected[0];
            expected.delete(0);
            if (pix !== want[31:0])
            begin
                $error("scaled_pixel: expected %h, got %h", want[31:0], pix);
                errors++;
            end
            if (done !== want[32])
            begin
                $error("frame_done: expected %0d, got %0d", want[32], done);
                errors++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;
    bit         no_idle;
    int         taken;

    downscale_scoreboard sb;

    aad_stream_if #(.WIDTH(PIX_W)) pixel_in ();
    aad_stream_if #(.WIDTH(PIX_W)) pixel_out ();

    area_average_downscale i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .source    (pixel_in),
        .scaled    (pixel_out)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("** area_average_downscale: FAILED **");
        $finish;
    end

    // sink side with stall bursts
    initial
    begin
        int stall;
        pixel_out.ready = 0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                pixel_out.ready = 0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 13);
                pixel_out.ready = 0;
            end
            else
                pixel_out.ready = 1;
        end
    end

    always @(posedge clk)
        if (rst_n && pixel_out.valid && pixel_out.ready)
            sb.check_result(pixel_out.data, pixel_out.last);

    task automatic write_reg(bit [1:0] idx, bit [9:0] value);
        @(negedge clk);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_size(bit [9:0] w, bit [9:0] h, bit [9:0] t);
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        write_reg(REG_TARGET_SIZE, t);
    endtask

    task automatic send_pixel(bit [31:0] px);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            pixel_in.valid = 0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
        @(negedge clk);
        pixel_in.valid = 1;
        pixel_in.data  = px;
        @(posedge clk);
        while (!pixel_in.ready)
            @(posedge clk);
        if (sb.note_pixel(px))
            taken++;
    endtask

    task automatic drain();
        @(negedge clk);
        pixel_in.valid = 0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic bit [31:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel());
        drain();
    endtask

    initial
    begin
        int w, h, t, frame;
        sb = new();
        rst_n           = 0;
        cfg_we          = 0;
        cfg_index       = REG_SOURCE_WIDTH;
        cfg_data        = 0;
        pixel_in.valid  = 0;
        pixel_in.data   = 0;
        pixel_in.last   = 0;
        no_idle         = 0;
        taken           = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset sizes, bit extremes
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hAAAA_AAAA);
        send_pixel(32'h5555_5555);
        drain();

        set_size(10'd1, 10'd1, 10'd1);
        run_pixels(3);
        set_size(10'd512, 10'd1, 10'd1);
        run_pixels(512);
        set_size(10'd1, 10'd512, 10'd1);
        run_pixels(512);
        set_size(10'd128, 10'd129, 10'd128);
        run_pixels(200);
        // upscaling and out of range sizes: ignored
        set_size(10'd3, 10'd8, 10'd4);
        run_pixels(3);
        set_size(10'd0, 10'd4, 10'd1);
        run_pixels(2);
        set_size(10'd600, 10'd4, 10'd2);
        run_pixels(2);
        set_size(10'd4, 10'd1023, 10'd2);
        run_pixels(2);
        set_size(10'd200, 10'd200, 10'd200);
        run_pixels(2);
        // target masked to 8 bits, then an unused index that leaves state alone
        set_size(10'd5, 10'd5, 10'h302);
        write_reg(REG_NONE, 10'h3FF);
        run_pixels(30);

        while (taken < TARGET_ITEMS)
        begin
            if (taken > TARGET_ITEMS - 250)
                no_idle = 1;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            t = $urandom_range(1, (w < h) ? w : h);
            if ($urandom_range(0, 15) == 0)
                t = $urandom_range(1, 13);
            set_size(10'(w), 10'(h), 10'(t));
            frame = w * h;
            run_pixels($urandom_range(0, 2) * frame + $urandom_range(1, frame));
        end

        drain();
        if (sb.errors == 0)
            $display("** area_average_downscale: PASSED **");
        else
            $display("** area_average_downscale: FAILED **");
        $finish;
    end

endmodule
